[rtl/core/ptlru_pkg.sv]
// Package with constants and types of the page table LRU frame manager.
package ptlru_pkg;
    localparam int PROCS      = 8;
    localparam int PAGES      = 16;
    localparam int FRAMES     = 64;
    localparam int STAMP_BITS = 32;
    localparam int PID_W      = $clog2(PROCS);
    localparam int PG_W       = $clog2(PAGES);
    localparam int FR_W       = $clog2(FRAMES);
    localparam int TOP_W      = $clog2(FRAMES + 1);
    localparam int ENT_W      = PID_W + PG_W;
    localparam int ENTRIES    = PROCS * PAGES;
    localparam int FC_W       = 32;

    localparam logic [2:0] ST_HIT         = 3'd0;
    localparam logic [2:0] ST_FAULT_FREE  = 3'd1;
    localparam logic [2:0] ST_FAULT_EVICT = 3'd2;
    localparam logic [2:0] ST_INVALID     = 3'd3;
    localparam logic [2:0] ST_RELEASED    = 3'd4;
    localparam logic [2:0] ST_NO_FRAME    = 3'd5;

    localparam logic REQ_ACCESS = 1'b0;
    localparam logic REQ_PROCESS_OVER = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK,
        S_DECIDE,
        S_SCAN,
        S_SCAN_LAST,
        S_POP,
        S_POP_WAIT,
        S_FINISH,
        S_REL,
        S_REL_LAST,
        S_OUT
    } t_state;
endpackage

[rtl/core/ptlru_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
module ptlru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/core/page_table_lru_frame_manager.sv]
// Top level of the page table LRU frame manager.
//
// One request enters on the s_axis channel: tuser holds req_type, tdata holds
// proc_id, page_number, page_limit, frame_quota and frames_held.  One result
// leaves on the m_axis channel with status, frame_number, victim_page and
// fault_count.  A request is handled alone, and a fault that evicts or any
// release walks the PAGES table entries of the process one a cycle through
// the memory read port.  Frame and stamp lie in one table RAM and the free
// stack in a second RAM; valid bits and fault counts are flip-flops cleared
// at reset.  The free stack keeps the lowest top it has reached since reset,
// and an entry below that mark was never written and reads as its own index.
// After reset the block takes a request at once.  While the receiver stalls
// the result is held in the output register and the next request waits at
// s_axis_tready.
module page_table_lru_frame_manager
    import ptlru_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // proc_id[2:0], page_number[7:3], page_limit[12:8], frame_quota[19:13],
    // frames_held[26:20], zero[31:27]
    input  logic [31:0] s_axis_tdata,
    // req_type[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], frame_number[8:3], victim_page[12:9], fault_count[44:13],
    // zero[47:45]
    output logic [47:0] m_axis_tdata
);
    localparam int TW = FR_W + STAMP_BITS;

    t_state r_state, n_state;

    logic                  r_req;
    logic [PID_W-1:0]      r_pid;
    logic [4:0]            r_page;
    logic [5:0]            r_limit;
    logic [6:0]            r_quota, r_held;
    logic [STAMP_BITS-1:0] r_refc;
    logic [ENTRIES-1:0]    r_valid;
    logic [FC_W-1:0]       r_fc [PROCS];
    logic [TOP_W-1:0]      r_top;
    logic [TOP_W-1:0]      r_hiwater;
    logic [PG_W:0]         r_scan;
    logic                  r_found;
    logic [PG_W-1:0]       r_vp, r_prevp;
    logic [STAMP_BITS-1:0] r_vstamp;
    logic [FR_W-1:0]       r_vframe;
    logic [2:0]            r_status;
    logic [FR_W-1:0]       r_frame;
    logic [PG_W-1:0]       r_victim;
    logic [FC_W-1:0]       r_fcout;
    logic                  r_mvalid;

    logic                  tbl_we;
    logic [ENT_W-1:0]      tbl_waddr, tbl_raddr;
    logic [TW-1:0]         tbl_wdata, tbl_rdata;
    logic                  f_we;
    logic [FR_W-1:0]       f_waddr, f_raddr, f_rdata;
    logic [FR_W-1:0]       f_rdata_w;

    ptlru_ram #(.WIDTH(TW), .DEPTH(ENTRIES)) u_table (
        .i_clk(i_clk), .i_we(tbl_we), .i_waddr(tbl_waddr), .i_wdata(tbl_wdata),
        .i_raddr(tbl_raddr), .o_rdata(tbl_rdata));
    ptlru_ram #(.WIDTH(FR_W), .DEPTH(FRAMES)) u_free (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_waddr), .i_wdata(f_rdata_w),
        .i_raddr(f_raddr), .o_rdata(f_rdata));

    logic              in_acc;
    logic [PG_W-1:0]   pg;
    logic [ENT_W-1:0]  ent;
    logic [PG_W-1:0]   scan_pg;
    logic [ENT_W-1:0]  scan_ent;
    logic [ENT_W-1:0]  prev_ent;
    logic              prev_valid;
    logic [FR_W-1:0]   rd_frame;
    logic [STAMP_BITS-1:0] rd_stamp;
    logic              evict;
    logic [FR_W-1:0]   pop_frame;
    logic [TOP_W-1:0]  pop_idx;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign pg       = r_page[PG_W-1:0];
    assign ent      = {r_pid, pg};
    assign scan_pg  = r_scan[PG_W-1:0];
    assign scan_ent = {r_pid, scan_pg};
    assign prev_ent = {r_pid, r_prevp};
    assign prev_valid = r_valid[prev_ent];
    assign rd_frame = tbl_rdata[FR_W-1:0];
    assign rd_stamp = tbl_rdata[TW-1:FR_W];
    assign evict    = (r_top == '0) || (r_held >= r_quota);
    assign pop_idx  = r_top - 1'b1;
    assign pop_frame = (pop_idx < r_hiwater) ? pop_idx[FR_W-1:0] : f_rdata;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (in_acc) n_state = S_LOOK;
            S_LOOK: begin
                if (r_req == REQ_PROCESS_OVER || r_page >= r_limit) begin
                    n_state = S_REL;
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (r_valid[ent]) begin
                    n_state = S_OUT;
                end else if (evict) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_POP;
                end
            end
            S_SCAN:      if (r_scan == PAGES[PG_W:0]) n_state = S_SCAN_LAST;
            S_SCAN_LAST: n_state = S_FINISH;
            S_POP:       n_state = S_POP_WAIT;
            S_POP_WAIT:  n_state = S_OUT;
            S_FINISH:    n_state = S_OUT;
            S_REL:       if (r_scan == PAGES[PG_W:0]) n_state = S_REL_LAST;
            S_REL_LAST:  n_state = S_OUT;
            S_OUT:       if (!r_mvalid || m_axis_tready) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == S_IDLE) && !r_mvalid;
        tbl_raddr = (r_state == S_LOOK) ? ent : scan_ent;
        tbl_we    = 1'b0;
        tbl_waddr = ent;
        tbl_wdata = {r_refc, r_frame};
        f_we    = 1'b0;
        f_waddr = r_top[FR_W-1:0];
        f_rdata_w = rd_frame;
        f_raddr = pop_idx[FR_W-1:0];
        unique case (r_state)
            S_DECIDE: begin
                tbl_we    = r_valid[ent];
                tbl_wdata = {r_refc, rd_frame};
            end
            S_FINISH: begin
                tbl_we    = (r_status != ST_NO_FRAME);
                tbl_wdata = {r_refc, (r_status == ST_FAULT_EVICT) ? r_vframe : pop_frame};
            end
            S_POP_WAIT: begin
                tbl_we    = 1'b1;
                tbl_wdata = {r_refc, pop_frame};
            end
            S_REL, S_REL_LAST: begin
                f_we = (r_scan != '0) && prev_valid && (r_top < FRAMES[TOP_W-1:0]);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_refc    <= '0;
            r_valid   <= '0;
            r_top     <= TOP_W'(FRAMES);
            r_hiwater <= TOP_W'(FRAMES);
            r_mvalid  <= 1'b0;
            for (int i = 0; i < PROCS; i++) r_fc[i] <= '0;
        end else begin
            r_state <= n_state;
            if (m_axis_tvalid && m_axis_tready) r_mvalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_req   <= s_axis_tuser;
                        r_pid   <= PID_W'(s_axis_tdata[2:0] % PROCS);
                        r_page  <= s_axis_tdata[7:3];
                        r_limit <= (s_axis_tdata[12:8] > PAGES) ? 6'(PAGES)
                                                                : {1'b0, s_axis_tdata[12:8]};
                        r_quota <= s_axis_tdata[19:13];
                        r_held  <= s_axis_tdata[26:20];
                    end
                end
                S_LOOK: begin
                    r_scan   <= '0;
                    r_found  <= 1'b0;
                    r_frame  <= '0;
                    r_victim <= '0;
                    if (r_req == REQ_ACCESS) r_refc <= r_refc + 1'b1;
                    if (r_req == REQ_PROCESS_OVER) begin
                        r_status <= ST_RELEASED;
                    end else begin
                        r_status <= ST_INVALID;
                    end
                end
                S_DECIDE: begin
                    if (r_valid[ent]) begin
                        r_status <= ST_HIT;
                        r_frame  <= rd_frame;
                    end else if (r_fc[r_pid] != '1) begin
                        r_fc[r_pid] <= r_fc[r_pid] + 1'b1;
                    end
                end
                S_SCAN, S_SCAN_LAST: begin
                    r_scan  <= r_scan + 1'b1;
                    r_prevp <= scan_pg;
                    if (r_scan != '0 && prev_valid &&
                        (!r_found || rd_stamp < r_vstamp)) begin
                        r_found  <= 1'b1;
                        r_vp     <= r_prevp;
                        r_vstamp <= rd_stamp;
                        r_vframe <= rd_frame;
                    end
                end
                S_FINISH: ;
                S_POP: ;
                S_POP_WAIT: ;
                S_REL, S_REL_LAST: begin
                    r_scan  <= r_scan + 1'b1;
                    r_prevp <= scan_pg;
                    if (r_scan != '0 && prev_valid) begin
                        r_valid[prev_ent] <= 1'b0;
                        if (r_top < FRAMES[TOP_W-1:0]) begin
                            r_top <= r_top + 1'b1;
                        end
                    end
                    if (r_state == S_REL_LAST) begin
                        r_fcout  <= r_fc[r_pid];
                        r_mvalid <= 1'b1;
                    end
                end
                S_OUT: ;
                default: ;
            endcase
            if (r_state == S_SCAN_LAST) begin
                if (r_found || (r_scan != '0 && prev_valid)) begin
                    r_status <= ST_FAULT_EVICT;
                end else if (r_top != '0) begin
                    r_status <= ST_FAULT_FREE;
                end else begin
                    r_status <= ST_NO_FRAME;
                end
            end
            if (r_state == S_FINISH) begin
                if (r_status == ST_FAULT_EVICT) begin
                    r_valid  <= (r_valid & ~(ENTRIES'(1) << {r_pid, r_vp}))
                              | (ENTRIES'(1) << ent);
                    r_frame  <= r_vframe;
                    r_victim <= r_vp;
                end else if (r_status == ST_FAULT_FREE) begin
                    r_valid[ent] <= 1'b1;
                    r_frame <= pop_frame;
                    r_top   <= pop_idx;
                    if (pop_idx < r_hiwater) r_hiwater <= pop_idx;
                end
                r_fcout  <= r_fc[r_pid];
                r_mvalid <= 1'b1;
            end
            if (r_state == S_POP) begin
                r_status <= ST_FAULT_FREE;
            end
            if (r_state == S_POP_WAIT) begin
                r_valid[ent] <= 1'b1;
                r_frame  <= pop_frame;
                r_top    <= pop_idx;
                if (pop_idx < r_hiwater) r_hiwater <= pop_idx;
                r_fcout  <= r_fc[r_pid];
                r_mvalid <= 1'b1;
            end
            if (r_state == S_DECIDE && r_valid[ent]) begin
                r_fcout  <= r_fc[r_pid];
                r_mvalid <= 1'b1;
            end
        end
    end

    always_comb begin
        m_axis_tvalid = r_mvalid;
        m_axis_tdata  = {3'b000, r_fcout, 4'(r_victim), 6'(r_frame), r_status};
    end
endmodule

[tb/tb_page_table_lru_frame_manager.sv]
// Testbench for the page table LRU frame manager with its own predictor and checks.
`timescale 1ns / 100ps

module tb_page_table_lru_frame_manager
    import ptlru_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 400;

    typedef struct {
        logic       req;
        logic [2:0] pid;
        logic [4:0] page;
        logic [4:0] limit;
        logic [6:0] quota;
        logic [6:0] held;
    } t_request;

    class frame_scoreboard;
        bit        page_ok[ENTRIES];
        bit [5:0]  page_frm[ENTRIES];
        bit [31:0] page_use[ENTRIES];
        bit [5:0]  free_frames[FRAMES];
        int        free_cnt;
        bit [31:0] access_clock;
        bit [31:0] faults[PROCS];
        bit [47:0] pending[$];
        int        errors;
        int        seen[6];

        function new();
            for (int n = 0; n < FRAMES; n++) free_frames[n] = 6'(n);
            free_cnt = FRAMES;
            access_clock = 0;
            errors = 0;
            foreach (faults[i]) faults[i] = 0;
            foreach (seen[i]) seen[i] = 0;
        endfunction

        function void free_process(int base);
            for (int p = 0; p < PAGES; p++) begin
                if (page_ok[base + p]) begin
                    page_ok[base + p] = 0;
                    if (free_cnt < FRAMES) begin
                        free_frames[free_cnt] = page_frm[base + p];
                        free_cnt++;
                    end
                end
            end
        endfunction

        function void note_request(t_request r);
            int        base;
            int        lim;
            int        e;
            int        vp;
            bit        found;
            logic [2:0] st;
            bit [5:0]  frm;
            bit [3:0]  victim;
            base = r.pid * PAGES;
            lim = (r.limit > PAGES) ? PAGES : r.limit;
            frm = 0;
            victim = 0;
            found = 0;
            vp = 0;
            if (r.req == REQ_PROCESS_OVER) begin
                free_process(base);
                st = ST_RELEASED;
            end else begin
                access_clock++;
                if (r.page >= lim) begin
                    free_process(base);
                    st = ST_INVALID;
                end else begin
                    e = base + r.page;
                    if (page_ok[e]) begin
                        page_use[e] = access_clock;
                        frm = page_frm[e];
                        st = ST_HIT;
                    end else begin
                        if (faults[r.pid] != 32'hFFFF_FFFF) faults[r.pid]++;
                        if (free_cnt == 0 || r.held >= r.quota) begin
                            for (int p = 0; p < PAGES; p++) begin
                                if (page_ok[base + p] &&
                                    (!found || page_use[base + p] < page_use[base + vp])) begin
                                    found = 1;
                                    vp = p;
                                end
                            end
                        end
                        if (found) begin
                            page_ok[base + vp] = 0;
                            frm = page_frm[base + vp];
                            victim = 4'(vp);
                            st = ST_FAULT_EVICT;
                        end else if (free_cnt > 0) begin
                            free_cnt--;
                            frm = free_frames[free_cnt];
                            st = ST_FAULT_FREE;
                        end else begin
                            st = ST_NO_FRAME;
                        end
                        if (st != ST_NO_FRAME) begin
                            page_ok[e] = 1;
                            page_frm[e] = frm;
                            page_use[e] = access_clock;
                        end
                    end
                end
            end
            pending.push_back({3'b000, faults[r.pid], victim, frm, st});
        endfunction

        function void check_result(logic [47:0] got);
            bit [47:0] want;
            if (pending.size() == 0) begin
                $error("result with no request outstanding: %h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (want[2:0] < 6) seen[want[2:0]]++;
            if (got[2:0] !== want[2:0]) begin
                $error("status: expected %0d, got %0d", want[2:0], got[2:0]);
                errors++;
            end
            if (got[8:3] !== want[8:3]) begin
                $error("frame_number: expected %0d, got %0d", want[8:3], got[8:3]);
                errors++;
            end
            if (got[12:9] !== want[12:9]) begin
                $error("victim_page: expected %0d, got %0d", want[12:9], got[12:9]);
                errors++;
            end
            if (got[44:13] !== want[44:13]) begin
                $error("fault_count: expected %0d, got %0d", want[44:13], got[44:13]);
                errors++;
            end
            if (got[47:45] !== want[47:45]) begin
                $error("padding: expected %0d, got %0d", want[47:45], got[47:45]);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;

    frame_scoreboard board;
    int  cycles;
    int  sent;
    bit  idling_on;

    page_table_lru_frame_manager dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic int gap_length();
        if (!idling_on) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
        return $urandom_range(5, 30);
    endfunction

    task automatic send_request(t_request r);
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  <= {5'b0, r.held, r.quota, r.limit, r.page, r.pid};
        s_axis_tuser  <= r.req;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_request(r);
        sent++;
        @(negedge i_clk);
    endtask

    function automatic t_request make_request(logic req, int pid, int page, int limit,
                                              int quota, int held);
        t_request r;
        r.req = req;
        r.pid = 3'(pid);
        r.page = 5'(page);
        r.limit = 5'(limit);
        r.quota = 7'(quota);
        r.held = 7'(held);
        return r;
    endfunction

    function automatic t_request random_request();
        t_request r;
        int pick;
        pick = $urandom_range(0, 99);
        r.pid   = 3'($urandom_range(0, 7));
        r.quota = 7'($urandom);
        r.held  = 7'($urandom);
        if (pick < 82) begin
            r.req   = REQ_ACCESS;
            r.limit = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(1, 31)) : 5'(PAGES);
            r.page  = 5'($urandom_range(0, ((r.limit > PAGES) ? PAGES : r.limit) - 1));
            if ($urandom_range(0, 1)) r.page = 5'($urandom_range(0, 5));
            if ($urandom_range(0, 2) == 0) r.quota = 7'd127;
        end else if (pick < 88) begin
            r.req   = REQ_PROCESS_OVER;
            r.page  = 5'($urandom);
            r.limit = 5'($urandom);
        end else begin
            r.req   = 1'($urandom);
            r.page  = 5'($urandom);
            r.limit = 5'($urandom);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
        if (cycles > CYCLE_LIMIT) begin
            $display("page_table_lru_frame_manager: mismatch");
            $finish;
        end
    end

    initial begin
        int hold;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            hold = gap_length();
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        board = new();
        cycles = 0;
        sent = 0;
        idling_on = 1'b1;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: releases, bounds, hits, eviction by quota and the clamped limit.
        send_request(make_request(REQ_PROCESS_OVER, 0, 0, 0, 0, 0));
        send_request(make_request(REQ_ACCESS, 7, 31, 31, 127, 0));
        send_request(make_request(REQ_ACCESS, 7, 15, 31, 127, 0));
        send_request(make_request(REQ_ACCESS, 7, 15, 16, 127, 0));
        send_request(make_request(REQ_ACCESS, 7, 0, 0, 127, 0));
        send_request(make_request(REQ_ACCESS, 1, 0, 1, 127, 0));
        send_request(make_request(REQ_ACCESS, 1, 0, 1, 127, 0));
        send_request(make_request(REQ_ACCESS, 1, 1, 1, 127, 0));
        send_request(make_request(REQ_ACCESS, 2, 3, 16, 0, 0));
        send_request(make_request(REQ_ACCESS, 2, 4, 16, 127, 0));
        send_request(make_request(REQ_ACCESS, 2, 5, 16, 127, 0));
        send_request(make_request(REQ_ACCESS, 2, 3, 16, 127, 0));
        send_request(make_request(REQ_ACCESS, 2, 6, 16, 2, 127));
        send_request(make_request(REQ_ACCESS, 2, 7, 16, 0, 0));
        send_request(make_request(REQ_ACCESS, 2, 6, 16, 127, 127));
        send_request(make_request(REQ_PROCESS_OVER, 2, 31, 31, 127, 127));
        send_request(make_request(REQ_PROCESS_OVER, 2, 0, 16, 0, 0));
        send_request(make_request(REQ_ACCESS, 3, 16, 16, 64, 64));
        send_request(make_request(REQ_ACCESS, 4, 0, 16, 64, 64));

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 100 == 50) idling_on = 1'b0;
            if (i % 100 == 0) idling_on = 1'b1;
            send_request(random_request());
        end
        s_axis_tvalid <= 1'b0;
        idling_on = 1'b1;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Sent %0d requests: %0d hits, %0d free-frame faults, %0d evictions,",
                 sent, board.seen[ST_HIT], board.seen[ST_FAULT_FREE],
                 board.seen[ST_FAULT_EVICT]);
        $display("%0d invalid references, %0d releases, %0d faults with no frame.",
                 board.seen[ST_INVALID], board.seen[ST_RELEASED], board.seen[ST_NO_FRAME]);
        if (board.errors == 0) begin
            $display("page_table_lru_frame_manager: match");
        end else begin
            $display("page_table_lru_frame_manager: mismatch");
        end
        $finish;
    end
endmodule
